// ===== sv/nearest_seed_pixel_labeler_core_macros.svh =====
// Assertion macros for the nearest seed pixel labeler.
// Included by the top level; no other dependencies.
`ifndef NEAREST_SEED_PIXEL_LABELER_CORE_MACROS_SVH
`define NEAREST_SEED_PIXEL_LABELER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NSPL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define NSPL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/nspl_pkg.sv =====
// Shared types and constants of the nearest seed pixel labeler.
// No dependencies; used by the interfaces, the cells and the top level.
package nspl_pkg;

  localparam int unsigned FieldCoordW = 12;
  localparam int unsigned SlotW       = 6;
  localparam int unsigned IndexW      = 6;
  localparam int unsigned CountW      = 7;
  localparam int unsigned ApbDataW    = 32;
  localparam int unsigned ApbAddrW    = 3;

  // Register index taken from paddr above the byte offset.
  localparam logic [ApbAddrW-3:0] RegSeedCount = '0;

  typedef enum logic {
    ReqLoad  = 1'b0,
    ReqQuery = 1'b1
  } req_e;

  // Control part of a beat travelling down the cell chain.
  typedef struct packed {
    logic              valid;
    req_e              req;
    logic              found;
    logic [SlotW-1:0]  slot;
    logic [IndexW-1:0] idx;
  } ctl_t;

endpackage

// ===== sv/nspl_in_if.sv =====
// Input channel of the labeler: seed loads and pixel queries.
// Depends on nspl_pkg for the field widths.
interface nspl_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 req_type;
  logic [nspl_pkg::SlotW-1:0]           seed_slot;
  logic [nspl_pkg::FieldCoordW-1:0]     seed_x;
  logic [nspl_pkg::FieldCoordW-1:0]     seed_y;
  logic [nspl_pkg::FieldCoordW-1:0]     pixel_row;
  logic [nspl_pkg::FieldCoordW-1:0]     pixel_col;

  modport source (
    output valid, req_type, seed_slot, seed_x, seed_y, pixel_row, pixel_col,
    input  ready
  );
  modport sink (
    input  valid, req_type, seed_slot, seed_x, seed_y, pixel_row, pixel_col,
    output ready
  );
endinterface

// ===== sv/nspl_out_if.sv =====
// Result channel of the labeler: nearest seed index and none flag.
// Depends on nspl_pkg for the field widths.
interface nspl_out_if;
  logic                          valid;
  logic                          ready;
  logic [nspl_pkg::IndexW-1:0]   nearest_index;
  logic                          none_found;

  modport source (
    output valid, nearest_index, none_found,
    input  ready
  );
  modport sink (
    input  valid, nearest_index, none_found,
    output ready
  );
endinterface

// ===== sv/nspl_cell.sv =====
// One cell of the labeler chain: holds one seed and updates the running best.
// Depends on nspl_pkg for the beat control struct.
module nspl_cell #(
  parameter int unsigned IDX         = 0,
  parameter int unsigned COORD_WIDTH = 12,
  parameter int unsigned DIST_W      = 25
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic                   active_i,
  input  nspl_pkg::ctl_t         ctl_i,
  input  logic [COORD_WIDTH-1:0] a_i,
  input  logic [COORD_WIDTH-1:0] b_i,
  input  logic [DIST_W-1:0]      dist_i,
  output nspl_pkg::ctl_t         ctl_o,
  output logic [COORD_WIDTH-1:0] a_o,
  output logic [COORD_WIDTH-1:0] b_o,
  output logic [DIST_W-1:0]      dist_o
);

  localparam int unsigned SqW = 2 * COORD_WIDTH;

  logic [COORD_WIDTH-1:0] sx_q, sy_q;
  logic                   seed_we;

  nspl_pkg::ctl_t         ctl1_q, ctl2_q, ctl2_d;
  logic [COORD_WIDTH-1:0] a1_q, b1_q, a2_q, b2_q;
  logic [DIST_W-1:0]      best1_q, best2_q, best2_d;
  logic [COORD_WIDTH-1:0] dx, dy;
  logic [SqW-1:0]         dx2_q, dy2_q, dx2_d, dy2_d;
  logic [DIST_W-1:0]      sum_dist;
  logic                   take;

  // A load beat addressed to this cell replaces its seed as it enters.
  assign seed_we = adv_i && ctl_i.valid && (ctl_i.req == nspl_pkg::ReqLoad) &&
                   (32'(ctl_i.slot) == IDX);

  always_ff @(posedge clk_i) begin
    if (seed_we) begin
      sx_q <= a_i;
      sy_q <= b_i;
    end
  end

  // First half: absolute differences and their squares.
  always_comb begin
    dx    = (a_i >= sx_q) ? (a_i - sx_q) : (sx_q - a_i);
    dy    = (b_i >= sy_q) ? (b_i - sy_q) : (sy_q - b_i);
    dx2_d = SqW'(dx) * SqW'(dx);
    dy2_d = SqW'(dy) * SqW'(dy);
  end

  // Second half: sum and compare; only a strictly smaller distance wins.
  always_comb begin
    sum_dist = DIST_W'(dx2_q) + DIST_W'(dy2_q);
    take     = ctl1_q.valid && (ctl1_q.req == nspl_pkg::ReqQuery) && active_i &&
               (!ctl1_q.found || (sum_dist < best1_q));
    ctl2_d   = ctl1_q;
    best2_d  = best1_q;
    if (take) begin
      ctl2_d.found = 1'b1;
      ctl2_d.idx   = nspl_pkg::IndexW'(IDX);
      best2_d      = sum_dist;
    end
  end

  // Control registers of both halves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else if (adv_i) begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl2_d;
    end
  end

  // Payload registers of both halves.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a1_q    <= a_i;
      b1_q    <= b_i;
      best1_q <= dist_i;
      dx2_q   <= dx2_d;
      dy2_q   <= dy2_d;
      a2_q    <= a1_q;
      b2_q    <= b1_q;
      best2_q <= best2_d;
    end
  end

  assign ctl_o  = ctl2_q;
  assign a_o    = a2_q;
  assign b_o    = b2_q;
  assign dist_o = best2_q;

endmodule

// ===== sv/nspl_apb_regs.sv =====
// APB-style configuration register block holding the seed count.
// Depends on nspl_pkg for address and data widths.
module nspl_apb_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [nspl_pkg::ApbAddrW-1:0]   paddr,
  input  logic [nspl_pkg::ApbDataW-1:0]   pwdata,
  output logic [nspl_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready,
  output logic [nspl_pkg::CountW-1:0]     seed_count_o
);

  logic [nspl_pkg::CountW-1:0]     seed_count_q;
  logic [nspl_pkg::ApbAddrW-3:0]   reg_idx;
  logic                            wr_en;

  assign reg_idx = paddr[nspl_pkg::ApbAddrW-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready &&
                   (reg_idx == nspl_pkg::RegSeedCount);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_count_q <= '0;
    end else if (wr_en) begin
      seed_count_q <= pwdata[nspl_pkg::CountW-1:0];
    end
  end

  // Read back; unmapped addresses read as zero.
  always_comb begin
    prdata = '0;
    if (reg_idx == nspl_pkg::RegSeedCount) begin
      prdata = nspl_pkg::ApbDataW'(seed_count_q);
    end
  end

  assign seed_count_o = seed_count_q;

endmodule

// ===== sv/nearest_seed_pixel_labeler_core.sv =====
// Channel   Dir  Beat contents
// in_i      in   req_type, seed_slot, seed_x, seed_y, pixel_row, pixel_col
// out_o     out  nearest_index, none_found (one beat per query, none per load)
// apb       in   seed_count at byte address 0
//
// Every beat walks a chain of MAX_SEEDS cells, two register levels per cell,
// so a query result reaches the output register after both levels of every
// cell; one beat enters per cycle while the chain is not stalled. Loads
// travel the same chain, so a query sees exactly the seeds loaded before it.
// When the output register is full and not taken, the whole chain stalls.
// Reset clears control state and the seed count; seed entries are undefined until loaded.
// Depends on nspl_pkg, nspl_in_if, nspl_out_if, nspl_cell and nspl_apb_regs.
module nearest_seed_pixel_labeler_core #(
  parameter int unsigned MAX_SEEDS   = 64,
  parameter int unsigned COORD_WIDTH = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  nspl_in_if.sink                         in_i,
  nspl_out_if.source                      out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [nspl_pkg::ApbAddrW-1:0]   paddr,
  input  logic [nspl_pkg::ApbDataW-1:0]   pwdata,
  output logic [nspl_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready
);

  `include "nearest_seed_pixel_labeler_core_macros.svh"

  localparam int unsigned DistW = 2 * COORD_WIDTH + 1;

  logic [nspl_pkg::CountW-1:0]  seed_count;
  logic [MAX_SEEDS-1:0]         active;
  logic                         adv;

  nspl_pkg::ctl_t               ctl_w  [MAX_SEEDS+1];
  logic [COORD_WIDTH-1:0]       a_w    [MAX_SEEDS+1];
  logic [COORD_WIDTH-1:0]       b_w    [MAX_SEEDS+1];
  logic [DistW-1:0]             dist_w [MAX_SEEDS+1];

  logic                         out_valid_q;
  logic [nspl_pkg::IndexW-1:0]  out_idx_q;
  logic                         out_none_q;
  nspl_pkg::ctl_t               last_ctl;

  // Configuration registers.
  nspl_apb_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .seed_count_o (seed_count)
  );

  // A cell takes part in the search when its index is below the count.
  always_comb begin
    for (int i = 0; i < MAX_SEEDS; i++) begin
      active[i] = 32'(seed_count) > 32'(i);
    end
  end

  // The chain moves whenever the output register can take a new result.
  assign adv      = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  // Head of the chain: loads carry seed coordinates in the coordinate lanes.
  always_comb begin
    ctl_w[0].valid = in_i.valid;
    ctl_w[0].req   = nspl_pkg::req_e'(in_i.req_type);
    ctl_w[0].found = 1'b0;
    ctl_w[0].slot  = in_i.seed_slot;
    ctl_w[0].idx   = '0;
    if (in_i.req_type == nspl_pkg::ReqQuery) begin
      a_w[0] = COORD_WIDTH'(in_i.pixel_row);
      b_w[0] = COORD_WIDTH'(in_i.pixel_col);
    end else begin
      a_w[0] = COORD_WIDTH'(in_i.seed_x);
      b_w[0] = COORD_WIDTH'(in_i.seed_y);
    end
    dist_w[0] = '0;
  end

  // Row of seed cells.
  for (genvar g = 0; g < MAX_SEEDS; g++) begin : g_cell
    nspl_cell #(
      .IDX         (g),
      .COORD_WIDTH (COORD_WIDTH),
      .DIST_W      (DistW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (adv),
      .active_i (active[g]),
      .ctl_i    (ctl_w[g]),
      .a_i      (a_w[g]),
      .b_i      (b_w[g]),
      .dist_i   (dist_w[g]),
      .ctl_o    (ctl_w[g+1]),
      .a_o      (a_w[g+1]),
      .b_o      (b_w[g+1]),
      .dist_o   (dist_w[g+1])
    );
  end

  assign last_ctl = ctl_w[MAX_SEEDS];

  // Output register: only query beats leave the chain as results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= last_ctl.valid && (last_ctl.req == nspl_pkg::ReqQuery);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_idx_q  <= last_ctl.found ? last_ctl.idx : '0;
      out_none_q <= !last_ctl.found;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.nearest_index = out_idx_q;
  assign out_o.none_found    = out_none_q;

  // A result without a seed always reports index zero.
  `NSPL_ASSERT_NOW(a_none_idx_zero, clk_i, rst_ni, out_valid_q && out_none_q, out_idx_q == '0, "none result with nonzero index")

  // A load leaving the chain never shows up as a result.
  `NSPL_ASSERT_NEXT(a_load_no_result, clk_i, rst_ni, adv && last_ctl.valid && (last_ctl.req == nspl_pkg::ReqLoad), !out_valid_q, "load beat produced a result")

  // While a result waits and is not taken, no input beat is accepted and the result stays valid.
  `NSPL_ASSERT_NEXT(a_stall_holds_chain, clk_i, rst_ni, out_valid_q && !out_o.ready && !in_i.ready, out_valid_q, "pending result dropped during stall")

endmodule
